### hdl/emac_pkg.sv
// ----------------------------------------------------------------------------
// emac_pkg
// Types, constants and the entropy table generator shared by the eigenvector
// moment accumulator.
// ----------------------------------------------------------------------------
package emac_pkg;

  localparam int unsigned TABLE_BITS_DEF  = 10;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned ENT_W           = 16;
  localparam int unsigned ACC_W           = 48;
  localparam logic [63:0] LN2_Q28         = 64'd186065279;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic        [9:0]  flip_count;
    logic signed [15:0] corr_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic        [25:0] flip_avg;
    logic signed [23:0] corr_avg;
    logic        [20:0] entropy;
    logic        [16:0] ipr;
  } out_item_t;

  typedef struct packed {
    logic        [25:0]      flip_term;
    logic signed [25:0]      corr_term;
    logic        [ENT_W-1:0] ent_term;
    logic        [16:0]      ipr_term;
    logic                    last;
  } term_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [63:0] log2_q30(logic [63:0] m);
    int unsigned k;
    logic [63:0] y;
    logic [63:0] frac;
    k    = 0;
    frac = 64'd0;
    for (int unsigned j = 0; j < 40; j++) begin
      if ((m >> (j + 1)) != 64'd0) begin
        k = j + 1;
      end
    end
    y = (k <= 30) ? (m << (30 - k)) : (m >> (k - 30));
    for (int unsigned i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y    = y >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    return (64'(k) << 30) + frac;
  endfunction

  // Value of -x ln x at the midpoint of bin i, in Q.16.
  function automatic logic [ENT_W-1:0] ent_entry(int unsigned b, int unsigned i);
    logic [63:0] m;
    logic [63:0] l;
    logic [63:0] t;
    logic [63:0] v;
    m = 64'(2 * i + 1);
    l = (64'(b + 1) << 30) - log2_q30(m);
    t = (l * LN2_Q28 + (64'd1 << 27)) >> 28;
    v = (m * t + (64'd1 << (b + 14))) >> (b + 15);
    return v[ENT_W-1:0];
  endfunction

endpackage

### hdl/emac_front.sv
// ----------------------------------------------------------------------------
// emac_front
// Accepts components, forms the weight and the four per-component terms in a
// two stage pipeline and hands them to the term queue.
// ----------------------------------------------------------------------------
module emac_front
  import emac_pkg::*;
#(
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  in_item_t      in_data,
  input  logic          q_full,
  output logic          q_push,
  output term_t         q_data
);

  localparam int unsigned TAB_N = (1 << TABLE_BITS) + 1;

  logic [ENT_W-1:0] ent_rom [0:TAB_N-1];

  for (genvar g = 0; g < TAB_N; g++) begin : g_rom
    assign ent_rom[g] = (g == TAB_N - 1) ? '0 : ent_entry(TABLE_BITS, g);
  end

  logic               adv;
  logic signed [31:0] sq;
  logic        [31:0] sq_rnd;

  logic               s1_v_r;
  logic        [16:0] s1_p_r;
  logic        [9:0]  s1_cnt_r;
  logic signed [15:0] s1_corr_r;
  logic               s1_nz_r;
  logic               s1_last_r;

  logic [TABLE_BITS:0] idx;
  logic signed [33:0]  pc;
  logic signed [33:0]  pc_rnd;
  logic        [33:0]  pp_rnd;

  logic               s2_v_r;
  term_t              s2_r;

  assign adv     = !(s2_v_r && q_full);
  assign in_full = !adv;
  assign q_push  = s2_v_r && !q_full;
  assign q_data  = s2_r;

  assign sq     = in_data.amplitude * in_data.amplitude;
  assign sq_rnd = unsigned'(sq) + 32'd8192;

  assign idx    = s1_p_r[16:16-TABLE_BITS];
  assign pc     = $signed({1'b0, s1_p_r}) * s1_corr_r;
  assign pc_rnd = pc + 34'sd128;
  assign pp_rnd = 34'(s1_p_r * s1_p_r) + 34'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p_r    <= sq_rnd[30:14];
      s1_cnt_r  <= in_data.flip_count;
      s1_corr_r <= in_data.corr_value;
      s1_nz_r   <= (in_data.amplitude != 16'sd0);
      s1_last_r <= in_data.last;

      s2_r.flip_term <= 26'(s1_p_r * s1_cnt_r);
      s2_r.corr_term <= pc_rnd[33:8];
      s2_r.ent_term  <= s1_nz_r ? ent_rom[idx] : '0;
      s2_r.ipr_term  <= pp_rnd[32:16];
      s2_r.last      <= s1_last_r;
    end
  end

endmodule

### hdl/emac_fifo.sv
// ----------------------------------------------------------------------------
// emac_fifo
// Short queue of per-component terms between the front and the back.
// ----------------------------------------------------------------------------
module emac_fifo
  import emac_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  term_t         wr_data,
  input  logic          pop,
  output term_t         rd_data,
  output queue_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  term_t         mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/emac_back.sv
// ----------------------------------------------------------------------------
// emac_back
// Adds queued terms into the four saturating accumulators and, on the final
// component, clamps the sums into the result register.
// ----------------------------------------------------------------------------
module emac_back
  import emac_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  term_t         q_head,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output out_item_t     out_data
);

  localparam logic [ACC_W-1:0]        U_MAX = {ACC_W{1'b1}};
  localparam logic signed [ACC_W-1:0] S_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic        [ACC_W-1:0] flip_acc_r;
  logic signed [ACC_W-1:0] corr_acc_r;
  logic        [ACC_W-1:0] ent_acc_r;
  logic        [ACC_W-1:0] ipr_acc_r;
  logic                    out_v_r;
  out_item_t               out_r;

  logic        [ACC_W:0]   flip_sum;
  logic signed [ACC_W:0]   corr_sum;
  logic        [ACC_W:0]   ent_sum;
  logic        [ACC_W:0]   ipr_sum;
  logic        [ACC_W-1:0] flip_nxt;
  logic signed [ACC_W-1:0] corr_nxt;
  logic        [ACC_W-1:0] ent_nxt;
  logic        [ACC_W-1:0] ipr_nxt;
  out_item_t               out_nxt;

  assign q_pop     = !q_empty && (!q_head.last || !out_v_r || out_pop);
  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  always_comb begin
    flip_sum = {1'b0, flip_acc_r} + (ACC_W + 1)'(q_head.flip_term);
    corr_sum = {corr_acc_r[ACC_W-1], corr_acc_r}
             + {{(ACC_W - 25){q_head.corr_term[25]}}, q_head.corr_term};
    ent_sum  = {1'b0, ent_acc_r} + (ACC_W + 1)'(q_head.ent_term);
    ipr_sum  = {1'b0, ipr_acc_r} + (ACC_W + 1)'(q_head.ipr_term);

    flip_nxt = flip_sum[ACC_W] ? U_MAX : flip_sum[ACC_W-1:0];
    ent_nxt  = ent_sum[ACC_W] ? U_MAX : ent_sum[ACC_W-1:0];
    ipr_nxt  = ipr_sum[ACC_W] ? U_MAX : ipr_sum[ACC_W-1:0];
    if (corr_sum[ACC_W] != corr_sum[ACC_W-1]) begin
      corr_nxt = corr_sum[ACC_W] ? S_MIN : S_MAX;
    end else begin
      corr_nxt = corr_sum[ACC_W-1:0];
    end

    out_nxt.flip_avg = (|flip_nxt[ACC_W-1:26]) ? '1 : flip_nxt[25:0];
    if ((&corr_nxt[ACC_W-1:23]) || !(|corr_nxt[ACC_W-1:23])) begin
      out_nxt.corr_avg = corr_nxt[23:0];
    end else begin
      out_nxt.corr_avg = corr_nxt[ACC_W-1] ? 24'sh800000 : 24'sh7FFFFF;
    end
    out_nxt.entropy = (|ent_nxt[ACC_W-1:21]) ? '1 : ent_nxt[20:0];
    if ((|ipr_nxt[ACC_W-1:17]) || (ipr_nxt[16] && (|ipr_nxt[15:0]))) begin
      out_nxt.ipr = 17'h10000;
    end else begin
      out_nxt.ipr = ipr_nxt[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_acc_r <= '0;
      corr_acc_r <= '0;
      ent_acc_r  <= '0;
      ipr_acc_r  <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (out_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_head.last) begin
          flip_acc_r <= '0;
          corr_acc_r <= '0;
          ent_acc_r  <= '0;
          ipr_acc_r  <= '0;
          out_v_r    <= 1'b1;
        end else begin
          flip_acc_r <= flip_nxt;
          corr_acc_r <= corr_nxt;
          ent_acc_r  <= ent_nxt;
          ipr_acc_r  <= ipr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_r <= out_nxt;
    end
  end

endmodule

### hdl/eigenvector_moment_accumulator_core.sv
// Throughput: one component per cycle while the term queue has room; a final
// component waits only while the previous result is still unread in the single
// result register. A final component accepted into an idle block passes the two
// front stages and the term queue, then one accumulate step into the result.
// Reset: synchronous, clears valid flags, queue pointers and accumulators; the
// entropy table is constant logic and needs no clearing pass.
// ----------------------------------------------------------------------------
// eigenvector_moment_accumulator_core
// Streams eigenvector components and returns expectation of flippable count,
// correlator expectation, Shannon entropy and inverse participation ratio.
// ----------------------------------------------------------------------------
module eigenvector_moment_accumulator_core
  import emac_pkg::*;
#(
  parameter int unsigned ENTROPY_TABLE_BITS = TABLE_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH        = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic          q_push;
  term_t         q_wr;
  logic          q_pop;
  term_t         q_head;
  queue_status_t q_status;

  emac_front #(
    .TABLE_BITS(ENTROPY_TABLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .q_full (q_status.full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  emac_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_head),
    .status (q_status)
  );

  emac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_status.empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(q_pop && q_head.last))
    else $error("result beat appeared without a final component");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_status.full)
    else $error("input stalled while the term queue had room");

  a_last_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last && !out_empty) |-> out_pop)
    else $error("final component taken while the result register was occupied");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !q_push)
    else $error("term queue written while full");
`endif

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eigenvector moment accumulator core. Vectors of
// random length and content are streamed in with random gaps. A scoreboard
// class predicts the four sums of each vector from its own entropy table and
// compares them field by field with what the core returns, under random
// reader stalls and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  import emac_pkg::*;

  localparam int unsigned TBITS       = TABLE_BITS_DEF;
  localparam int unsigned TAB_N       = (1 << TBITS) + 1;
  localparam longint      ACC_CAP     = (longint'(1) << 48) - 1;
  localparam longint      CORR_HI     = (longint'(1) << 47) - 1;
  localparam longint      CORR_LO     = -(longint'(1) << 47);
  localparam longint      FLIP_CAP    = 67108863;
  localparam longint      ENT_CAP     = 2097151;
  localparam longint      IPR_CAP     = 65536;
  localparam int          ITEMS       = 1350;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 800000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  int in_quiet;
  int out_quiet;

  class moment_scoreboard;
    longint unsigned ent_table[TAB_N];
    longint          flip_sum;
    longint          corr_sum;
    longint          ent_sum;
    longint          ipr_sum;
    out_item_t       expected_sums[$];
    int              errors;

    function new();
      longint unsigned m;
      longint unsigned l;
      longint unsigned t;
      for (int i = 0; i < TAB_N - 1; i++) begin
        m = 64'(2 * i + 1);
        l = (64'(TBITS + 1) << 30) - log2_fixed30(m);
        t = (l * LN2_Q28 + (64'd1 << 27)) >> 28;
        ent_table[i] = (m * t + (64'd1 << (TBITS + 14))) >> (TBITS + 15);
      end
      ent_table[TAB_N-1] = 0;
      clear_sums();
      errors = 0;
    endfunction

    static function longint unsigned log2_fixed30(longint unsigned m);
      int unsigned     k;
      longint unsigned y;
      longint unsigned frac;
      k    = 0;
      frac = 0;
      while (k < 40 && (m >> (k + 1)) != 0) k++;
      y = (k <= 30) ? (m << (30 - k)) : (m >> (k - 30));
      for (int i = 1; i <= 30; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y    = y >> 1;
          frac = frac | (64'd1 << (30 - i));
        end
      end
      return (64'(k) << 30) + frac;
    endfunction

    static function longint sat_add(longint acc, longint term);
      longint s;
      s = acc + term;
      return (s > ACC_CAP) ? ACC_CAP : s;
    endfunction

    function void clear_sums();
      flip_sum = 0;
      corr_sum = 0;
      ent_sum  = 0;
      ipr_sum  = 0;
    endfunction

    function void note_component(in_item_t it);
      longint    amp;
      longint    corr;
      longint    p;
      longint    idx;
      longint    cr;
      out_item_t res;
      amp  = $signed(it.amplitude);
      corr = $signed(it.corr_value);
      p    = (amp * amp + 8192) >>> 14;
      flip_sum = sat_add(flip_sum, p * longint'(it.flip_count));
      corr_sum = corr_sum + ((p * corr + 128) >>> 8);
      if (corr_sum > CORR_HI) corr_sum = CORR_HI;
      if (corr_sum < CORR_LO) corr_sum = CORR_LO;
      if (amp != 0) begin
        idx = p >>> (16 - TBITS);
        if (idx > TAB_N - 1) idx = TAB_N - 1;
        ent_sum = sat_add(ent_sum, longint'(ent_table[idx]));
      end
      ipr_sum = sat_add(ipr_sum, (p * p + 32768) >>> 16);
      if (it.last) begin
        cr = corr_sum;
        if (cr > 8388607) cr = 8388607;
        if (cr < -8388608) cr = -8388608;
        res.flip_avg = (flip_sum > FLIP_CAP) ? FLIP_CAP[25:0] : flip_sum[25:0];
        res.corr_avg = cr[23:0];
        res.entropy  = (ent_sum > ENT_CAP) ? ENT_CAP[20:0] : ent_sum[20:0];
        res.ipr      = (ipr_sum > IPR_CAP) ? IPR_CAP[16:0] : ipr_sum[16:0];
        expected_sums.push_back(res);
        clear_sums();
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_sums(out_item_t got);
      out_item_t want;
      if (expected_sums.size() == 0) begin
        $display("%0t: result beat with none expected: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      compare_field("flip_avg", want.flip_avg, got.flip_avg);
      compare_field("corr_avg", $signed(want.corr_avg), $signed(got.corr_avg));
      compare_field("entropy", want.entropy, got.entropy);
      compare_field("ipr", want.ipr, got.ipr);
    endfunction
  endclass

  moment_scoreboard sb;

  eigenvector_moment_accumulator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(int amp, int cnt, int corr, bit last);
    in_item_t it;
    it.amplitude  = 16'(amp);
    it.flip_count = 10'(cnt);
    it.corr_value = 16'(corr);
    it.last       = last;
    return it;
  endfunction

  function automatic int rand_amplitude();
    int mag;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(0, 180) - 90;
      2: begin
        case ($urandom_range(0, 2))
          0: return -32768;
          1: return 32767;
          default: return -32767;
        endcase
      end
      3: begin
        mag = $urandom_range(17900, 21900);
        return $urandom_range(0, 1) ? mag : -mag;
      end
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  task automatic push_component(in_item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    sb.note_component(it);
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : result_reader
    int  stall;
    int  g;
    int  results;
    bit  held;
    out_pop   = 1'b0;
    out_quiet = 0;
    stall     = 0;
    results   = 0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && results == 20) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        g = pick_gap(out_quiet);
        if (g > 0) begin
          stall = g - 1;
          out_pop <= 1'b0;
        end else begin
          out_pop <= 1'b1;
        end
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        sb.check_sums(out_data);
        results++;
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    int       len;
    int       sent;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    in_quiet  = 0;
    sent      = 0;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    push_component(make_item(-32768, 1023, 32767, 1'b1), 0);
    push_component(make_item(-32768, 1023, 32767, 1'b0), 0);
    push_component(make_item(-32768, 1023, 32767, 1'b1), 0);
    push_component(make_item(-32768, 0, -32768, 1'b0), 1);
    push_component(make_item(-32768, 0, -32768, 1'b1), 0);
    push_component(make_item(0, 1023, 32767, 1'b0), 0);
    push_component(make_item(1, 512, -1, 1'b0), 2);
    push_component(make_item(-1, 511, 1, 1'b0), 0);
    push_component(make_item(-90, 1, -32768, 1'b0), 0);
    push_component(make_item(181, 5, 256, 1'b0), 0);
    push_component(make_item(32767, 341, -21846, 1'b0), 0);
    push_component(make_item(-32767, 682, 21845, 1'b0), 0);
    push_component(make_item(19880, 1023, -256, 1'b0), 3);
    push_component(make_item(0, 0, 0, 1'b1), 0);
    push_component(make_item(0, 1023, -32768, 1'b1), 0);
    push_component(make_item(1, 0, 32767, 1'b1), 0);
    push_component(make_item(23170, 100, 12800, 1'b1), 0);

    while (sent < ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      for (int j = 0; j < len; j++) begin
        it = make_item(rand_amplitude(), rand_count(), $urandom_range(0, 65535),
                       j == len - 1);
        push_component(it, pick_gap(in_quiet));
        sent++;
      end
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/emac_pkg.sv
hdl/emac_front.sv
hdl/emac_fifo.sv
hdl/emac_back.sv
hdl/eigenvector_moment_accumulator_core.sv
verif/tb.sv
